[rtl/core/dsf_pkg.sv]
// Shared types, constants and digit functions for the seven-segment frame formatter.
// No dependencies; used by dsf_bcd_pipe and decimal_to_seven_segment_frames.
package dsf_pkg;

  typedef enum logic [1:0] {
    OP_INT   = 2'd0,
    OP_FIXED = 2'd1,
    OP_RAW   = 2'd2,
    OP_NONE  = 2'd3
  } dsf_op_t;

  localparam logic [13:0] INT_LIMIT = 14'd9999;
  localparam logic [13:0] WRAP_BASE = 14'd10000;
  localparam logic [7:0]  DP_BIT    = 8'h80;

  typedef logic [3:0][3:0] dsf_digits_t;

  typedef struct packed {
    logic       raw;
    logic       fixed;
    logic [2:0] raw_reg;
    logic [7:0] raw_seg;
  } dsf_ctl_t;

  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h30;
      4'd2:    p = 8'h6D;
      4'd3:    p = 8'h79;
      4'd4:    p = 8'h33;
      4'd5:    p = 8'h5B;
      4'd6:    p = 8'h5F;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h7B;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] position_reg(input logic [1:0] pos);
    logic [2:0] r;
    case (pos)
      2'd0:    r = 3'd3;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd1;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  // Leading decimal digit of n for a constant unit; n must be below ten units.
  function automatic logic [3:0] lead_digit(input logic [13:0] n, input logic [13:0] unit);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (n >= 14'(k) * unit) begin
        q = 4'(k);
      end
    end
    return q;
  endfunction

endpackage

[rtl/core/dsf_bcd_pipe.sv]
// Three-stage pipeline that splits a value below 10000 into four decimal digits.
// Depends on dsf_pkg for the digit and control types.
module dsf_bcd_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [13:0]         in_n,
  input  dsf_pkg::dsf_ctl_t   in_ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output dsf_pkg::dsf_digits_t out_digits,
  output dsf_pkg::dsf_ctl_t   out_ctl
);
  import dsf_pkg::*;

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  logic [9:0]  rem1_r;
  logic [6:0]  rem2_r;
  logic [3:0]  d0_r, d1_r, d0b_r;
  dsf_digits_t dig3_r;
  dsf_ctl_t    ctl1_r, ctl2_r, ctl3_r;

  logic [3:0]  q1, q2, q3;
  logic [13:0] r1_full, r2_full, r3_full;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    q1      = lead_digit(in_n, 14'd1000);
    r1_full = in_n - 14'(q1) * 14'd1000;
    q2      = lead_digit({4'd0, rem1_r}, 14'd100);
    r2_full = {4'd0, rem1_r} - 14'(q2) * 14'd100;
    q3      = lead_digit({7'd0, rem2_r}, 14'd10);
    r3_full = {7'd0, rem2_r} - 14'(q3) * 14'd10;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rem1_r <= r1_full[9:0];
      d0_r   <= q1;
      ctl1_r <= in_ctl;
    end
    if (rdy2) begin
      rem2_r <= r2_full[6:0];
      d0b_r  <= d0_r;
      d1_r   <= q2;
      ctl2_r <= ctl1_r;
    end
    if (rdy3) begin
      dig3_r <= {r3_full[3:0], q3, d1_r, d0b_r};
      ctl3_r <= ctl2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_digits = dig3_r;
  assign out_ctl    = ctl3_r;

endmodule

[rtl/core/decimal_to_seven_segment_frames.sv]
// Top level of the seven-segment frame formatter: input stage, digit pipeline, frame serializer.
// Depends on dsf_pkg and dsf_bcd_pipe.
//
//   channel | ports                                              | direction
//   in      | in_valid in_stall in_opcode in_value in_position in_segments | into block
//   out     | out_valid out_stall out_digit_register out_segment_byte out_last | out of block
//
// An item passes the input stage and the digit pipeline before the serializer frames it.
// The serializer sends one frame per cycle unless out_stall is high; integer and fixed items
// are four frames each and raw writes one frame each, so raw writes sustain one item per cycle.
// Unused opcode 3 is dropped at the input stage and produces no transaction.
// Reset is synchronous and clears the valid bits and the frame index.
// A stall on the output holds the current frame and backs up the pipeline to in_stall.
module decimal_to_seven_segment_frames (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_value,
  input  logic [1:0]  in_position,
  input  logic [7:0]  in_segments,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_digit_register,
  output logic [7:0]  out_segment_byte,
  output logic        out_last
);
  import dsf_pkg::*;

  logic        valid0_r, ready0;
  logic [13:0] n0_r, n_nxt;
  dsf_ctl_t    ctl0_r, ctl_nxt;

  logic        pipe_ready, pipe_valid;
  dsf_digits_t pipe_digits;
  dsf_ctl_t    pipe_ctl;

  logic             ser_valid_r, ser_raw_r, ser_free, ser_done;
  logic [1:0]       ser_idx_r;
  logic [2:0]       ser_reg_r;
  logic [3:0][7:0]  ser_seg_r, seg_nxt;

  always_comb begin
    if (dsf_op_t'(in_opcode) == OP_INT) begin
      n_nxt = (in_value > INT_LIMIT) ? INT_LIMIT : in_value;
    end else begin
      n_nxt = (in_value >= WRAP_BASE) ? in_value - WRAP_BASE : in_value;
    end
    ctl_nxt.raw     = dsf_op_t'(in_opcode) == OP_RAW;
    ctl_nxt.fixed   = dsf_op_t'(in_opcode) == OP_FIXED;
    ctl_nxt.raw_reg = position_reg(in_position);
    ctl_nxt.raw_seg = in_segments;
  end

  assign ready0   = !valid0_r || pipe_ready;
  assign in_stall = !ready0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (ready0) begin
      valid0_r <= in_valid && (dsf_op_t'(in_opcode) != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready0) begin
      n0_r   <= n_nxt;
      ctl0_r <= ctl_nxt;
    end
  end

  dsf_bcd_pipe u_bcd (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (valid0_r),
    .in_ready   (pipe_ready),
    .in_n       (n0_r),
    .in_ctl     (ctl0_r),
    .out_valid  (pipe_valid),
    .out_ready  (ser_free),
    .out_digits (pipe_digits),
    .out_ctl    (pipe_ctl)
  );

  assign out_valid          = ser_valid_r;
  assign out_last           = ser_raw_r || (ser_idx_r == 2'd3);
  assign out_digit_register = ser_raw_r ? ser_reg_r : position_reg(ser_idx_r);
  assign out_segment_byte   = ser_seg_r[0];

  assign ser_done = ser_valid_r && !out_stall && out_last;
  assign ser_free = !ser_valid_r || ser_done;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      seg_nxt[i] = digit_pattern(pipe_digits[i]);
    end
    if (pipe_ctl.fixed) begin
      seg_nxt[1] = seg_nxt[1] | DP_BIT;
    end
    if (pipe_ctl.raw) begin
      seg_nxt[0] = pipe_ctl.raw_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_idx_r   <= 2'd0;
    end else if (ser_free) begin
      ser_valid_r <= pipe_valid;
      ser_idx_r   <= 2'd0;
    end else if (!out_stall) begin
      ser_idx_r <= ser_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      ser_seg_r <= seg_nxt;
      ser_raw_r <= pipe_ctl.raw;
      ser_reg_r <= pipe_ctl.raw_reg;
    end else if (!out_stall) begin
      ser_seg_r <= {8'h00, ser_seg_r[3:1]};
    end
  end

`ifndef SYNTHESIS
  a_frames_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("transaction ended before its last frame");

  a_register_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_register >= 3'd1) && (out_digit_register <= 3'd4))
    else $error("digit register out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> valid0_r && !pipe_ready)
    else $error("input stalled while the input stage could advance");
`endif

endmodule
